### design/spcmm_pkg.sv
// Shared types, constants and the control store for the semiprime classifier.
// Used by spcmm_seq and by semiprime_count_min_max_core; depends on nothing.
package spcmm_pkg;

  localparam int unsigned CountW   = 16;
  localparam logic [CountW-1:0] CountTop = '1;
  localparam int unsigned StepW    = 4;

  typedef logic [StepW-1:0] step_t;

  // Datapath actions, one per control word.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SQ,
    OP_DSTART,
    OP_DNEXT,
    OP_SETHIT,
    OP_CLRHIT,
    OP_PASS2,
    OP_UPDATE
  } op_e;

  // Jump conditions; a jump goes to the target, otherwise the step advances.
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NOSTART,
    C_SQGT,
    C_BUSY,
    C_REMZ,
    C_PASS1,
    C_OUTFULL
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_t target;
  } ctl_t;

  typedef struct packed {
    logic start;
    logic sq_gt;
    logic busy;
    logic rem_zero;
    logic pass1;
    logic out_full;
  } flags_t;

  localparam step_t S_IDLE   = 4'd0;
  localparam step_t S_SQ     = 4'd1;
  localparam step_t S_CMP    = 4'd2;
  localparam step_t S_DSTART = 4'd3;
  localparam step_t S_DWAIT  = 4'd4;
  localparam step_t S_CHK    = 4'd5;
  localparam step_t S_DNEXT  = 4'd6;
  localparam step_t S_NODIV  = 4'd7;
  localparam step_t S_FOUND  = 4'd8;
  localparam step_t S_PASS2  = 4'd9;
  localparam step_t S_OWAIT  = 4'd10;
  localparam step_t S_UPDATE = 4'd11;

  // Program: find the least divisor of x (2, then odd d while d*d <= x).
  // First pass on the input; if one is found, rerun on the cofactor, which
  // must then have no divisor for the input to be a semiprime.
  function automatic ctl_t ucode(input step_t addr);
    ctl_t w;
    w = '{op: OP_NONE, cond: C_ALWAYS, target: S_IDLE};
    unique case (addr)
      S_IDLE:   w = '{op: OP_LOAD,   cond: C_NOSTART, target: S_IDLE};
      S_SQ:     w = '{op: OP_SQ,     cond: C_NEVER,   target: S_IDLE};
      S_CMP:    w = '{op: OP_NONE,   cond: C_SQGT,    target: S_NODIV};
      S_DSTART: w = '{op: OP_DSTART, cond: C_NEVER,   target: S_IDLE};
      S_DWAIT:  w = '{op: OP_NONE,   cond: C_BUSY,    target: S_DWAIT};
      S_CHK:    w = '{op: OP_NONE,   cond: C_REMZ,    target: S_FOUND};
      S_DNEXT:  w = '{op: OP_DNEXT,  cond: C_ALWAYS,  target: S_SQ};
      S_NODIV:  w = '{op: OP_SETHIT, cond: C_ALWAYS,  target: S_OWAIT};
      S_FOUND:  w = '{op: OP_CLRHIT, cond: C_PASS1,   target: S_OWAIT};
      S_PASS2:  w = '{op: OP_PASS2,  cond: C_ALWAYS,  target: S_SQ};
      S_OWAIT:  w = '{op: OP_NONE,   cond: C_OUTFULL, target: S_OWAIT};
      S_UPDATE: w = '{op: OP_UPDATE, cond: C_ALWAYS,  target: S_IDLE};
      default:  w = '{op: OP_NONE,   cond: C_ALWAYS,  target: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

### design/spcmm_div.sv
// Restoring divider, one quotient bit per cycle, for the trial divisions.
// Standalone; no package dependency.
module spcmm_div #(
  parameter int unsigned DW = 20,
  parameter int unsigned SW = 12
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [SW-1:0] divisor_i,
  output logic          busy_o,
  output logic [DW-1:0] quot_o,
  output logic [SW-1:0] rem_o
);

  localparam int unsigned CntW = $clog2(DW + 1);

  logic            busy_q, busy_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DW-1:0]   quo_q, quo_d;
  logic [SW-1:0]   rem_q, rem_d;
  logic [SW:0]     trial;
  logic [SW:0]     diff;

  assign trial = {rem_q, quo_q[DW-1]};
  assign diff  = trial - {1'b0, divisor_i};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(DW);
      quo_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      // remainder stays below the divisor, so the top bit of diff is dropped
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = diff[SW-1:0];
        quo_d = {quo_q[DW-2:0], 1'b1};
      end else begin
        rem_d = trial[SW-1:0];
        quo_d = {quo_q[DW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

### design/spcmm_seq.sv
// Microcode sequencer: step counter, control store lookup, conditional jumps.
// Depends on spcmm_pkg for the control word, flags and program.
module spcmm_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  spcmm_pkg::flags_t flags_i,
  output spcmm_pkg::ctl_t   ctl_o
);

  spcmm_pkg::step_t upc_q, upc_d;
  spcmm_pkg::ctl_t  word;
  logic             take;

  assign word = spcmm_pkg::ucode(upc_q);

  always_comb begin
    unique case (word.cond)
      spcmm_pkg::C_NEVER:   take = 1'b0;
      spcmm_pkg::C_ALWAYS:  take = 1'b1;
      spcmm_pkg::C_NOSTART: take = !flags_i.start;
      spcmm_pkg::C_SQGT:    take = flags_i.sq_gt;
      spcmm_pkg::C_BUSY:    take = flags_i.busy;
      spcmm_pkg::C_REMZ:    take = flags_i.rem_zero;
      spcmm_pkg::C_PASS1:   take = flags_i.pass1;
      spcmm_pkg::C_OUTFULL: take = flags_i.out_full;
      default:              take = 1'b1;
    endcase
    upc_d = take ? word.target : upc_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= spcmm_pkg::S_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

  assign ctl_o = word;

endmodule

### design/semiprime_count_min_max_core.sv
// Channel | dir | handshake           | payload
// in      | in  | in_valid/in_ready   | value_i
// out     | out | out_valid/out_ready | is_semiprime, semiprime_count, smallest/largest_found
//
// One item at a time. Each trial divisor runs through the bit-serial divider;
// an item tries up to about 2^(WIDTH/2-1) divisors in each of two passes. The
// result then holds in the output register; the next item is taken while it
// waits. Reset clears count, sets minimum to all ones, maximum to zero. A
// stalled result blocks only the update of the next item.
// Depends on spcmm_pkg, spcmm_seq and spcmm_div.
module semiprime_count_min_max_core #(
  parameter int unsigned WIDTH = 20
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [WIDTH-1:0]             value_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         is_semiprime_o,
  output logic [spcmm_pkg::CountW-1:0] semiprime_count_o,
  output logic [WIDTH-1:0]             smallest_found_o,
  output logic [WIDTH-1:0]             largest_found_o
);

  localparam int unsigned DW  = WIDTH / 2 + 2;
  localparam int unsigned SQW = 2 * DW;
  localparam int unsigned CW  = spcmm_pkg::CountW;

  spcmm_pkg::ctl_t   ctl;
  spcmm_pkg::flags_t flags;

  logic [WIDTH-1:0] n_q, n_d, x_q, x_d;
  logic [DW-1:0]    d_q, d_d;
  logic [SQW-1:0]   sq_q, sq_d;
  logic             pass_q, pass_d, hit_q, hit_d;
  logic [CW-1:0]    count_q, count_d;
  logic [WIDTH-1:0] min_q, min_d, max_q, max_d;
  logic             out_valid_q, out_valid_d;
  logic             out_hit_q, out_hit_d;
  logic [CW-1:0]    out_count_q, out_count_d;
  logic [WIDTH-1:0] out_min_q, out_min_d, out_max_q, out_max_d;

  logic             div_start, div_busy;
  logic [WIDTH-1:0] div_quot;
  logic [DW-1:0]    div_rem;

  spcmm_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctl_o   (ctl)
  );

  spcmm_div #(
    .DW (WIDTH),
    .SW (DW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (x_q),
    .divisor_i  (d_q),
    .busy_o     (div_busy),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign in_ready_o = (ctl.op == spcmm_pkg::OP_LOAD);
  assign div_start  = (ctl.op == spcmm_pkg::OP_DSTART);

  assign flags.start    = in_valid_i;
  assign flags.sq_gt    = sq_q > {{(SQW-WIDTH){1'b0}}, x_q};
  assign flags.busy     = div_busy;
  assign flags.rem_zero = (div_rem == '0);
  assign flags.pass1    = pass_q;
  assign flags.out_full = out_valid_q && !out_ready_i;

  always_comb begin
    n_d         = n_q;
    x_d         = x_q;
    d_d         = d_q;
    sq_d        = sq_q;
    pass_d      = pass_q;
    hit_d       = hit_q;
    count_d     = count_q;
    min_d       = min_q;
    max_d       = max_q;
    out_hit_d   = out_hit_q;
    out_count_d = out_count_q;
    out_min_d   = out_min_q;
    out_max_d   = out_max_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (ctl.op)
      spcmm_pkg::OP_LOAD: begin
        if (in_valid_i) begin
          n_d    = value_i;
          x_d    = value_i;
          d_d    = DW'(2);
          pass_d = 1'b0;
        end
      end
      spcmm_pkg::OP_SQ:     sq_d = d_q * d_q;
      spcmm_pkg::OP_DNEXT:  d_d = (d_q == DW'(2)) ? DW'(3) : d_q + DW'(2);
      // no divisor: in the cofactor pass the cofactor is prime
      spcmm_pkg::OP_SETHIT: hit_d = pass_q;
      spcmm_pkg::OP_CLRHIT: hit_d = 1'b0;
      spcmm_pkg::OP_PASS2: begin
        x_d    = div_quot;
        d_d    = DW'(2);
        pass_d = 1'b1;
      end
      spcmm_pkg::OP_UPDATE: begin
        if (hit_q) begin
          if (count_q != spcmm_pkg::CountTop) begin
            count_d = count_q + 1'b1;
          end
          if (n_q < min_q) begin
            min_d = n_q;
          end
          if (n_q > max_q) begin
            max_d = n_q;
          end
        end
        out_hit_d   = hit_q;
        out_count_d = count_d;
        out_min_d   = min_d;
        out_max_d   = max_d;
        out_valid_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      min_q       <= '1;
      max_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      min_q       <= min_d;
      max_q       <= max_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q         <= n_d;
    x_q         <= x_d;
    d_q         <= d_d;
    sq_q        <= sq_d;
    pass_q      <= pass_d;
    hit_q       <= hit_d;
    out_hit_q   <= out_hit_d;
    out_count_q <= out_count_d;
    out_min_q   <= out_min_d;
    out_max_q   <= out_max_d;
  end

  assign out_valid_o       = out_valid_q;
  assign is_semiprime_o    = out_hit_q;
  assign semiprime_count_o = out_count_q;
  assign smallest_found_o  = out_min_q;
  assign largest_found_o   = out_max_q;

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("sequencer stayed idle after accepting a beat");

  a_no_restart_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_count_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 count_q >= $past(count_q))
    else $error("semiprime count decreased");

  a_hit_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_semiprime_o |-> smallest_found_o <= largest_found_o
      && semiprime_count_o != '0)
    else $error("reported semiprime without consistent min/max/count");

endmodule

### test/semiprime_tally_checker.sv
`timescale 1ns / 100ps
// Scoreboard for semiprime_count_min_max_core: predicts the running semiprime
// tally for every input beat and compares it with every output beat.
// Depends on spcmm_pkg for the count width and its saturation value.
module semiprime_tally_checker #(
  parameter int unsigned WIDTH = 20
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic [WIDTH-1:0]             value_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic                         is_semiprime_i,
  input  logic [spcmm_pkg::CountW-1:0] semiprime_count_i,
  input  logic [WIDTH-1:0]             smallest_found_i,
  input  logic [WIDTH-1:0]             largest_found_i,
  output int unsigned                  fail_count_o,
  output int unsigned                  pending_o
);

  typedef struct {
    logic                         hit;
    logic [spcmm_pkg::CountW-1:0] count;
    logic [WIDTH-1:0]             least;
    logic [WIDTH-1:0]             greatest;
  } tally_t;

  tally_t expected_tallies[$];

  logic [spcmm_pkg::CountW-1:0] run_count;
  logic [WIDTH-1:0]             run_min;
  logic [WIDTH-1:0]             run_max;

  function automatic bit is_prime_num(input longint unsigned n);
    longint unsigned d;
    if (n < 2) return 1'b0;
    if (n[0] == 1'b0) return n == 2;
    for (d = 3; d * d <= n; d += 2) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Least divisor first, then the cofactor must be prime.
  function automatic bit is_two_prime_product(input longint unsigned n);
    longint unsigned d;
    if (n < 4) return 1'b0;
    if (is_prime_num(n)) return 1'b0;
    if (n[0] == 1'b0) return is_prime_num(n / 2);
    for (d = 3; d * d <= n; d += 2) begin
      if (n % d == 0) return is_prime_num(n / d);
    end
    return 1'b0;
  endfunction

  // Advance the running tally by one number and return what the block reports.
  function automatic tally_t tally_value(input logic [WIDTH-1:0] v);
    tally_t t;
    t.hit = is_two_prime_product(longint'(v));
    if (t.hit) begin
      if (run_count != spcmm_pkg::CountTop) run_count++;
      if (v < run_min) run_min = v;
      if (v > run_max) run_max = v;
    end
    t.count    = run_count;
    t.least    = run_min;
    t.greatest = run_max;
    return t;
  endfunction

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tally_t want;
    if (!rst_ni) begin
      run_count = '0;
      run_min   = '1;
      run_max   = '0;
      expected_tallies.delete();
      fail_count_o = 0;
    end else begin
      // Pop before push: a result can never belong to the beat taken this edge.
      if (out_valid_i && out_ready_i) begin
        if (expected_tallies.size() == 0) begin
          $display("%0t ns: unexpected result beat, expected none, actual %0b/%0d/%0d/%0d",
                   $time, is_semiprime_i, semiprime_count_i, smallest_found_i,
                   largest_found_i);
          fail_count_o++;
        end else begin
          want = expected_tallies.pop_front();
          check_field("is_semiprime", want.hit, is_semiprime_i);
          check_field("semiprime_count", want.count, semiprime_count_i);
          check_field("smallest_found", want.least, smallest_found_i);
          check_field("largest_found", want.greatest, largest_found_i);
        end
      end
      if (in_valid_i && in_ready_i) expected_tallies.push_back(tally_value(value_i));
    end
    pending_o = expected_tallies.size();
  end

endmodule

### test/tb.sv
`timescale 1ns / 100ps
// Top of the semiprime classifier testbench: clock, reset, number stimulus and
// result back-pressure. Depends on semiprime_count_min_max_core and semiprime_tally_checker.
module tb;

  localparam int unsigned WIDTH         = 20;
  localparam int unsigned RandomItems   = 270;
  localparam int unsigned QuietTail     = 40;
  localparam int unsigned DrainPoint    = 120;
  localparam int unsigned WatchdogLimit = 100000;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [WIDTH-1:0]             value = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic                         is_semiprime;
  logic [spcmm_pkg::CountW-1:0] semiprime_count;
  logic [WIDTH-1:0]             smallest_found;
  logic [WIDTH-1:0]             largest_found;
  int unsigned                  fail_count;
  int unsigned                  pending;

  bit          quiet_tail = 1'b0;
  int unsigned stall_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned sent_items = 0;
  int unsigned small_primes[$];
  int unsigned low_prime_count = 0;

  semiprime_count_min_max_core #(.WIDTH(WIDTH)) uut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .value_i           (value),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .is_semiprime_o    (is_semiprime),
    .semiprime_count_o (semiprime_count),
    .smallest_found_o  (smallest_found),
    .largest_found_o   (largest_found)
  );

  semiprime_tally_checker #(.WIDTH(WIDTH)) tally_check (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_i        (in_ready),
    .value_i           (value),
    .out_valid_i       (out_valid),
    .out_ready_i       (out_ready),
    .is_semiprime_i    (is_semiprime),
    .semiprime_count_i (semiprime_count),
    .smallest_found_i  (smallest_found),
    .largest_found_i   (largest_found),
    .fail_count_o      (fail_count),
    .pending_o         (pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Stall the result side in bursts of random length, none in the tail.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 15);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("%0t ns: watchdog, no beat for %0d cycles", $time, idle_cycles);
        $display("FAIL");
        $finish;
      end
    end
  end

  // Hold valid and the number until the beat is taken.
  task automatic send_number(input logic [WIDTH-1:0] v);
    value    <= v;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sent_items++;
  endtask

  // Built products of two primes, most with a small first factor (cheap for
  // the block) and a few with both drawn from all primes below 1024, near misses
  // with three factors, and plain numbers of small, medium and full width.
  function automatic logic [WIDTH-1:0] pick_value();
    int unsigned sel;
    int unsigned p;
    int unsigned q;
    int unsigned r;
    sel = $urandom_range(0, 99);
    if (sel < 45) begin
      p = small_primes[$urandom_range(0, low_prime_count - 1)];
      q = small_primes[$urandom_range(0, small_primes.size() - 1)];
      return WIDTH'(p * q);
    end else if (sel < 50) begin
      p = small_primes[$urandom_range(0, small_primes.size() - 1)];
      q = small_primes[$urandom_range(0, small_primes.size() - 1)];
      return WIDTH'(p * q);
    end else if (sel < 60) begin
      p = small_primes[$urandom_range(0, low_prime_count - 1)];
      q = small_primes[$urandom_range(0, low_prime_count - 1)];
      r = small_primes[$urandom_range(0, low_prime_count - 1)];
      return WIDTH'(p * q * r);
    end else if (sel < 80) begin
      return WIDTH'($urandom_range(0, 4095));
    end else if (sel < 92) begin
      return WIDTH'($urandom_range(0, 65535));
    end
    return WIDTH'($urandom());
  endfunction

  initial begin
    bit          composite[1024];
    int unsigned directed_values[$];
    int unsigned m;
    directed_values = '{0, 1, 2, 3, 1042441, 961, 49, 25, 15, 9, 6, 4, 5, 8, 12, 30,
                        20'hFFFFF, 1048573, 20'hAAAAA, 20'h55555, 1048574};
    for (int unsigned n = 2; n < 1024; n++) begin
      if (!composite[n]) begin
        small_primes.push_back(n);
        if (n < 64) low_prime_count++;
        for (m = n * n; m < 1024; m += n) composite[m] = 1'b1;
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_values[i]) send_number(WIDTH'(directed_values[i]));

    for (int unsigned i = 0; i < RandomItems; i++) begin
      if (i == RandomItems - QuietTail) quiet_tail <= 1'b1;
      if (i == DrainPoint) begin
        // Drop valid and let every outstanding result come back first.
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
      end else if (i < RandomItems - QuietTail && $urandom_range(0, 6) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      send_number(pick_value());
    end

    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (20) @(posedge clk);

    $display("Sent %0d numbers (%0d directed edge cases, rest random), with one full drain.",
             sent_items, directed_values.size());
    $display("Final tally: %0d semiprimes, least %0d, greatest %0d; %0d mismatches.",
             semiprime_count, smallest_found, largest_found, fail_count);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
